### rtl/core/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Types and constants shared by the byte ring buffer FIFO modules.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DATA_W = 8;
  localparam int LEN_W  = 11;
  localparam int IDX_W  = 10;
  localparam int CNT_W  = 16;

  localparam logic [LEN_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_PEEK    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  burst_len;
    logic [IDX_W-1:0]  elem_index;
  } brb_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              read_valid;
    logic              burst_error;
    logic [LEN_W-1:0]  level;
    logic              empty_res;
    logic [CNT_W-1:0]  error_count;
  } brb_out_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_req_t;

endpackage

### rtl/core/brb_mem.sv
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brb_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [7:0]                 rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointer, level, burst and error bookkeeping; issues store accesses.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fire,
  input  brb_pkg::brb_in_t            item,
  input  logic                        cfg_fire,
  input  logic [brb_pkg::LEN_W-1:0]   cfg_data,
  output brb_pkg::mem_req_t           req,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic [7:0]                  wr_data,
  output logic [$clog2(DEPTH)-1:0]    rd_addr,
  output brb_pkg::brb_out_t           status
);

  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam logic [16:0] DEPTH_V = 17'(DEPTH);

  logic [LEN_W-1:0] fifo_size;
  logic [AW-1:0]    read_pointer,   read_pointer_next;
  logic [AW-1:0]    write_pointer,  write_pointer_next;
  logic [LEN_W-1:0] fill_level,     fill_level_next;
  logic [CNT_W-1:0] rejected_total, rejected_total_next;
  logic             burst_accepted, burst_accepted_next;
  logic             burst_rejected, burst_rejected_next;
  logic [LEN_W-1:0] latched_len,    latched_len_next;

  logic [LEN_W-1:0] size_eff;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [LEN_W-1:0] off,
                                             input logic [LEN_W-1:0] size);
    logic [EW-1:0] s;
    s = EW'(base) + EW'(off);
    if (s >= EW'(size)) begin
      s = s - EW'(size);
    end
    return s[AW-1:0];
  endfunction

  always_comb begin
    if (fifo_size == '0) begin
      size_eff = 11'd1;
    end else if (17'(fifo_size) > DEPTH_V) begin
      size_eff = LEN_W'(DEPTH);
    end else begin
      size_eff = fifo_size;
    end
  end

  always_comb begin
    logic [LEN_W-1:0] idx;
    logic [LEN_W:0]   room;
    read_pointer_next   = read_pointer;
    write_pointer_next  = write_pointer;
    fill_level_next     = fill_level;
    rejected_total_next = rejected_total;
    burst_accepted_next = burst_accepted;
    burst_rejected_next = burst_rejected;
    latched_len_next    = latched_len;
    req                 = '0;
    wr_addr             = wrap_add(write_pointer, LEN_W'(item.elem_index), size_eff);
    wr_data             = item.data;
    rd_addr             = wrap_add(read_pointer, LEN_W'(item.elem_index), size_eff);
    status              = '0;
    idx                 = LEN_W'(item.elem_index);
    room                = (LEN_W+1)'(item.burst_len) + (LEN_W+1)'(fill_level);

    unique case (item.op)
      OP_WRITE: begin
        if (idx == '0) begin
          latched_len_next = item.burst_len;
          if (item.burst_len == '0 || room > (LEN_W+1)'(size_eff)) begin
            rejected_total_next = rejected_total + 1'b1;
            burst_accepted_next = 1'b0;
            burst_rejected_next = 1'b1;
            status.burst_error  = 1'b1;
          end else begin
            burst_accepted_next = 1'b1;
            burst_rejected_next = 1'b0;
          end
        end else if (burst_rejected && idx < latched_len) begin
          status.burst_error = 1'b1;
        end
        if (burst_accepted_next && idx < latched_len_next) begin
          req.wr_en = fire;
          if (idx + 1'b1 == latched_len_next) begin
            write_pointer_next  = wrap_add(write_pointer, latched_len_next, size_eff);
            fill_level_next     = fill_level + latched_len_next;
            burst_accepted_next = 1'b0;
          end
        end
        if (burst_rejected_next && idx + 1'b1 >= latched_len_next) begin
          burst_rejected_next = 1'b0;
        end
      end
      OP_PEEK: begin
        if (item.burst_len == '0 || item.burst_len > fill_level) begin
          status.burst_error = 1'b1;
          if (idx == '0) begin
            rejected_total_next = rejected_total + 1'b1;
          end
        end else if (idx < item.burst_len) begin
          status.read_valid = 1'b1;
          req.rd_en         = fire;
        end
      end
      OP_ADVANCE: begin
        if (item.burst_len <= fill_level) begin
          read_pointer_next = wrap_add(read_pointer, item.burst_len, size_eff);
          fill_level_next   = fill_level - item.burst_len;
        end
      end
      OP_CLEAR: begin
        read_pointer_next   = '0;
        write_pointer_next  = '0;
        fill_level_next     = '0;
        rejected_total_next = '0;
        burst_accepted_next = 1'b0;
        burst_rejected_next = 1'b0;
        latched_len_next    = '0;
      end
      default: begin
      end
    endcase

    status.level       = fill_level_next;
    status.empty_res   = (read_pointer_next == write_pointer_next) && (fill_level_next == '0);
    status.error_count = rejected_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_size      <= SIZE_RESET;
      read_pointer   <= '0;
      write_pointer  <= '0;
      fill_level     <= '0;
      rejected_total <= '0;
      burst_accepted <= 1'b0;
      burst_rejected <= 1'b0;
      latched_len    <= '0;
    end else if (cfg_fire) begin
      fifo_size      <= cfg_data;
      read_pointer   <= '0;
      write_pointer  <= '0;
      fill_level     <= '0;
      rejected_total <= '0;
      burst_accepted <= 1'b0;
      burst_rejected <= 1'b0;
      latched_len    <= '0;
    end else if (fire) begin
      read_pointer   <= read_pointer_next;
      write_pointer  <= write_pointer_next;
      fill_level     <= fill_level_next;
      rejected_total <= rejected_total_next;
      burst_accepted <= burst_accepted_next;
      burst_rejected <= burst_rejected_next;
      latched_len    <= latched_len_next;
    end
  end

endmodule

### rtl/core/byte_ring_buffer_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_fifo
// Byte circular FIFO with all-or-nothing write bursts, peek and advance.
// ----------------------------------------------------------------------------
// Result: registered when the input beat is taken; a peek that reads the byte
//   store captures the store's registered read data after a pending stage.
// Throughput: 1 item per cycle unless the output stalls; a store-reading peek
//   holds the input while the store read completes.
// Reset: pointers, level, error count and burst state clear; size is 1024.
//   The byte store is not cleared.
module byte_ring_buffer_fifo #(
  parameter int DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  brb_pkg::brb_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output brb_pkg::brb_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brb_pkg::LEN_W-1:0]   cfg_data
);

  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic              fire;
  logic              cfg_fire;
  logic              pend;
  mem_req_t          req;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [7:0]        wr_data;
  logic [7:0]        rd_data;
  brb_out_t          status;

  assign in_ready  = !rst && !pend && (!out_valid || out_ready);
  assign fire      = in_valid && in_ready;
  // size writes only with nothing in flight
  assign cfg_ready = !rst && !pend && !out_valid && !in_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;

  brb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (in_data),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_data),
    .req      (req),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .status   (status)
  );

  brb_mem #(.DEPTH(DEPTH)) u_mem (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= !req.rd_en;
        pend      <= req.rd_en;
      end else if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= status;
    end else if (pend) begin
      out_data.read_data <= rd_data;
    end
  end

  a_pend_blocks_out: assert property (@(posedge clk) disable iff (rst)
    pend |-> !out_valid && !in_ready)
    else $error("result shown while store read pending");

  a_read_sets_pend: assert property (@(posedge clk) disable iff (rst)
    fire && req.rd_en |=> pend)
    else $error("store read issued without pending stage");

  a_pend_one_cycle: assert property (@(posedge clk) disable iff (rst)
    pend |=> out_valid && !pend)
    else $error("pending peek did not complete in one cycle");

  a_read_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_valid |-> !out_data.burst_error)
    else $error("peeked byte flagged as error");

endmodule

### test/tb_byte_ring_buffer_fifo.sv
// ----------------------------------------------------------------------------
// tb_byte_ring_buffer_fifo
// Self-checking bench for the byte ring buffer FIFO. A directed table covers
// rejected bursts, peeks, advances and clear. Random phases then run
// burst-shaped traffic at several ring sizes. A cycle-free model of the ring
// predicts untyped results. Random stalls are applied on input and output.
// ----------------------------------------------------------------------------
module tb_byte_ring_buffer_fifo;
  import brb_pkg::*;

  localparam int SLOTS_MAX      = 1024;
  localparam int STALL_PCT      = 19;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_MAX     = 10;

  typedef struct {
    brb_in_t  item;
    bit       typed;
    brb_out_t res;
  } plan_row_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  brb_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  brb_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data  = '0;

  // ring model
  logic [DATA_W-1:0] mirror_mem  [SLOTS_MAX];
  bit                written_map [SLOTS_MAX];
  int unsigned       rd_ptr, wr_ptr, fill, wr_len;
  logic [CNT_W-1:0]  rejects;
  bit                wr_open, wr_dropped;
  logic [LEN_W-1:0]  size_reg;

  brb_out_t    due_results [$];
  brb_out_t    want;
  plan_row_t   plan [$];
  int unsigned items_sent;
  int unsigned bad_results;
  int unsigned quiet_cycles;
  bit          calm;

  byte_ring_buffer_fifo #(.DEPTH(SLOTS_MAX)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned slot_count();
    if (size_reg == 0) return 1;
    if (size_reg > SLOTS_MAX) return SLOTS_MAX;
    return size_reg;
  endfunction

  function automatic int unsigned ring_add(int unsigned base, int unsigned off);
    return (base + off) % slot_count();
  endfunction

  function automatic void restart_state();
    rd_ptr     = 0;
    wr_ptr     = 0;
    fill       = 0;
    wr_len     = 0;
    rejects    = '0;
    wr_open    = 1'b0;
    wr_dropped = 1'b0;
  endfunction

  function automatic brb_in_t pack_item(op_t op, logic [DATA_W-1:0] d, int unsigned len,
                                        int unsigned idx);
    brb_in_t it;
    it.op         = op;
    it.data       = d;
    it.burst_len  = LEN_W'(len);
    it.elem_index = IDX_W'(idx);
    return it;
  endfunction

  function automatic plan_row_t plan_row(op_t op, logic [DATA_W-1:0] d, int unsigned len,
                                         int unsigned idx, bit typed, bit be,
                                         int unsigned lvl, bit empty, int unsigned cnt);
    plan_row_t r;
    r.item              = pack_item(op, d, len, idx);
    r.typed             = typed;
    r.res               = '0;
    r.res.burst_error   = be;
    r.res.level         = LEN_W'(lvl);
    r.res.empty_res     = empty;
    r.res.error_count   = CNT_W'(cnt);
    return r;
  endfunction

  // a peek may only land on a slot that has been written at some point
  function automatic bit store_ready_for(brb_in_t it);
    if (it.op != OP_PEEK || it.burst_len == 0 || it.burst_len > fill ||
        it.elem_index >= it.burst_len) return 1'b1;
    return written_map[ring_add(rd_ptr, it.elem_index)];
  endfunction

  function automatic void ring_step(input brb_in_t it, output brb_out_t res,
                                    output bit effect);
    int unsigned len, idx, slot;
    len    = it.burst_len;
    idx    = it.elem_index;
    res    = '0;
    effect = 1'b1;
    case (it.op)
      OP_WRITE: begin
        if (idx == 0) begin
          wr_len = len;
          if (len == 0 || len + fill > slot_count()) begin
            rejects++;
            wr_open         = 1'b0;
            wr_dropped      = 1'b1;
            res.burst_error = 1'b1;
          end else begin
            wr_open    = 1'b1;
            wr_dropped = 1'b0;
          end
        end else if (wr_dropped && idx < wr_len) begin
          res.burst_error = 1'b1;
        end else if (!(wr_open && idx < wr_len)) begin
          effect = 1'b0;
        end
        if (wr_open && idx < wr_len) begin
          slot              = ring_add(wr_ptr, idx);
          mirror_mem[slot]  = it.data;
          written_map[slot] = 1'b1;
          if (idx + 1 == wr_len) begin
            wr_ptr  = ring_add(wr_ptr, wr_len);
            fill   += wr_len;
            wr_open = 1'b0;
          end
        end
        if (wr_dropped && idx + 1 >= wr_len) wr_dropped = 1'b0;
      end
      OP_PEEK: begin
        if (len == 0 || len > fill) begin
          res.burst_error = 1'b1;
          if (idx == 0) rejects++;
        end else if (idx < len) begin
          res.read_data  = mirror_mem[ring_add(rd_ptr, idx)];
          res.read_valid = 1'b1;
        end
      end
      OP_ADVANCE: begin
        if (len <= fill) begin
          rd_ptr  = ring_add(rd_ptr, len);
          fill   -= len;
          effect  = len != 0;
        end else begin
          effect = 1'b0;
        end
      end
      OP_CLEAR: begin
        restart_state();
      end
    endcase
    res.level       = LEN_W'(fill);
    res.empty_res   = rd_ptr == wr_ptr && fill == 0;
    res.error_count = rejects;
  endfunction

  task automatic push_beat(input brb_in_t it, input bit typed = 1'b0,
                           input brb_out_t typed_res = '0);
    brb_out_t res;
    bit       effect;
    if (!store_ready_for(it)) return;
    while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    ring_step(it, res, effect);
    due_results.push_back(typed ? typed_res : res);
    if (effect) items_sent++;
  endtask

  task automatic set_size(input logic [LEN_W-1:0] val);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = val;
    restart_state();
  endtask

  task automatic write_burst();
    int unsigned free, len, count, skip, i;
    bit          dropped;
    free = slot_count() - fill;
    if (free == 0 || $urandom_range(0, 99) < 12)
      len = (free < SLOTS_MAX && $urandom_range(0, 3) != 0) ?
            $urandom_range(free + 1, SLOTS_MAX) : 0;
    else if ($urandom_range(0, 9) == 0)
      len = $urandom_range(1, free < 40 ? free : 40);
    else
      len = $urandom_range(1, free < 8 ? free : 8);
    dropped = len == 0 || len + fill > slot_count();
    count   = len;
    skip    = SLOTS_MAX;
    if (dropped) count = $urandom_range(1, 3);
    else if ($urandom_range(0, 19) == 0) count = $urandom_range(1, len);
    else if (len > 1 && $urandom_range(0, 19) == 0) skip = $urandom_range(1, len - 1);
    for (i = 0; i < count; i++)
      if (i != skip) push_beat(pack_item(OP_WRITE, 8'($urandom), len, i));
  endtask

  task automatic peek_run();
    int unsigned len, n, i;
    if (fill == 0 || $urandom_range(0, 99) < 12) begin
      len = (fill < SLOTS_MAX && $urandom_range(0, 2) != 0) ?
            $urandom_range(fill + 1, SLOTS_MAX) : 0;
      n = $urandom_range(1, 2);
      for (i = 0; i < n; i++)
        push_beat(pack_item(OP_PEEK, 8'($urandom), len,
                            i == 0 ? 0 : $urandom_range(0, SLOTS_MAX - 1)));
    end else begin
      len = $urandom_range(1, fill);
      n   = len < 4 ? len : 4;
      for (i = 0; i < n; i++) push_beat(pack_item(OP_PEEK, 8'($urandom), len, i));
      if (len > n)
        push_beat(pack_item(OP_PEEK, 8'($urandom), len, $urandom_range(n, len - 1)));
      if (len < SLOTS_MAX && $urandom_range(0, 5) == 0)
        push_beat(pack_item(OP_PEEK, 8'($urandom), len, $urandom_range(len, SLOTS_MAX - 1)));
    end
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] size_val, input int unsigned budget,
                           input bit fill_first);
    int unsigned stop, pick, len, i;
    set_size(size_val);
    stop = items_sent + budget;
    if (fill_first)
      for (i = 0; i < SLOTS_MAX; i++)
        push_beat(pack_item(OP_WRITE, 8'($urandom), SLOTS_MAX, i));
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        write_burst();
      end else if (pick < 65) begin
        peek_run();
      end else if (pick < 84) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SLOTS_MAX) :
              $urandom_range(0, fill);
        push_beat(pack_item(OP_ADVANCE, 8'($urandom), len, $urandom_range(0, SLOTS_MAX - 1)));
      end else if (pick < 85) begin
        push_beat(pack_item(OP_CLEAR, 8'($urandom), $urandom_range(0, SLOTS_MAX),
                            $urandom_range(0, SLOTS_MAX - 1)));
      end else begin
        push_beat(pack_item(op_t'($urandom_range(0, 3)), 8'($urandom),
                            $urandom_range(0, SLOTS_MAX), $urandom_range(0, SLOTS_MAX - 1)));
      end
    end
  endtask

  always @(posedge clk) out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX)
          $display("unexpected result beat: level %0d error_count %0d",
                   out_data.level, out_data.error_count);
      end else begin
        want = due_results.pop_front();
        if (out_data.read_data !== want.read_data || out_data.read_valid !== want.read_valid ||
            out_data.burst_error !== want.burst_error || out_data.level !== want.level ||
            out_data.empty_res !== want.empty_res ||
            out_data.error_count !== want.error_count) begin
          bad_results++;
          if (bad_results <= REPORT_MAX)
            $display({"result mismatch (exp/got): read_data %0h/%0h read_valid %0d/%0d ",
                      "burst_error %0d/%0d level %0d/%0d empty %0d/%0d error_count %0d/%0d"},
                     want.read_data, out_data.read_data, want.read_valid, out_data.read_valid,
                     want.burst_error, out_data.burst_error, want.level, out_data.level,
                     want.empty_res, out_data.empty_res, want.error_count,
                     out_data.error_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_byte_ring_buffer_fifo: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    size_reg     = SIZE_RESET;
    items_sent   = 0;
    bad_results  = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    restart_state();

    //                   op          data   len   idx  typed be lvl empty cnt
    plan.push_back(plan_row(OP_ADVANCE, 8'h00, 0,    0,    1, 0, 0, 1, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h00, 0,    0,    1, 1, 0, 1, 1));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 1,    0,    1, 1, 0, 1, 2));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 0,    5,    1, 1, 0, 1, 2));
    plan.push_back(plan_row(OP_WRITE,   8'hff, 3,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h5a, 3,    1,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h00, 3,    2,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h11, 3,    3,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 3,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 3,    2,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 3,    3,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 4,    0,    1, 1, 3, 0, 3));
    plan.push_back(plan_row(OP_ADVANCE, 8'h00, 4,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_ADVANCE, 8'h00, 1,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 2,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h00, 1024, 0,    1, 1, 2, 0, 4));
    plan.push_back(plan_row(OP_WRITE,   8'haa, 1024, 1023, 1, 1, 2, 0, 4));
    plan.push_back(plan_row(OP_WRITE,   8'h01, 1,    1,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h33, 2,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 2,    1,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h44, 1,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_PEEK,    8'h00, 3,    2,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_ADVANCE, 8'h00, 3,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h77, 2,    0,    0, 0, 0, 0, 0));
    plan.push_back(plan_row(OP_CLEAR,   8'h00, 0,    0,    1, 0, 0, 1, 0));
    plan.push_back(plan_row(OP_WRITE,   8'h12, 2,    1,    0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) push_beat(plan[i].item, plan[i].typed, plan[i].res);

    run_phase(11'd0,    95,   1'b0);
    run_phase(11'd1,    95,   1'b0);
    run_phase(11'd2,    95,   1'b0);
    run_phase(11'd2047, 1174, 1'b1);
    run_phase(11'd7,    95,   1'b0);
    calm = 1'b1;
    run_phase(11'd1023, 120,  1'b0);
    calm = 1'b0;
    run_phase(LEN_W'($urandom_range(3, 1022)), 95, 1'b0);
    run_phase(11'd1024, 95,   1'b0);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (bad_results == 0)
      $display("tb_byte_ring_buffer_fifo: done, clean");
    else
      $display("tb_byte_ring_buffer_fifo: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/core/brb_pkg.sv
rtl/core/brb_mem.sv
rtl/core/brb_ctrl.sv
rtl/core/byte_ring_buffer_fifo.sv
test/tb_byte_ring_buffer_fifo.sv
